[src/ihwm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihwm_pkg
// Shared types, codes and widths for the indexed Horner weight multiplier.
// ----------------------------------------------------------------------------
package ihwm_pkg;

    // Field widths of one transaction
    localparam int DATA_W  = 48;   // signed Q16.32
    localparam int HALF_W  = DATA_W / 2;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int FRAC_W  = 32;
    localparam int WIDX_W  = 10;
    localparam int CIDX_W  = 8;
    localparam int ORDER_W = 4;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int S_TDATA_W = 72;  // 70 bits of fields, padded to whole bytes
    localparam int M_TDATA_W = 48;

    // Parameter defaults
    localparam int NUM_WEIGHTS_DEF = 1024;
    localparam int NUM_COEFFS_DEF  = 256;
    localparam int MAX_ORDER_DEF   = 15;

    // Q16.32 range limits
    localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Partial products per full multiply (24x24 pieces of a 48x48 product)
    localparam logic [2:0] MUL_STEPS = 3'd4;

    typedef enum logic [REQ_W-1:0] {
        REQ_WR_COEF   = 2'd0,
        REQ_WR_WEIGHT = 2'd1,
        REQ_APPLY     = 2'd2,
        REQ_RD_WEIGHT = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_SAT   = 2'd2
    } stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FETCH,
        ST_RD_TAKE,
        ST_H_FETCH,
        ST_H_LOAD,
        ST_W_FETCH,
        ST_M_SETUP,
        ST_MUL,
        ST_FIN,
        ST_H_ADD,
        ST_OUT
    } state_t;

endpackage

[src/indexed_horner_weight_multiply.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_horner_weight_multiply
// Coefficient and weight stores with a Horner evaluator that scales a weight.
//
// One transaction is handled at a time; s_tready is high only while the block
// is idle, and a finished result may wait in the output register while the
// next transaction is taken. Writes go straight to the output state, a weight
// read passes a fetch and a take state first, and an apply clamps its order
// to MAX_ORDER. Every Q16.32 product runs through one 24x24 multiplier in
// four passes, so each Horner step runs setup, four partial products plus
// one drain, truncate/saturate and the coefficient add. An apply whose
// coefficient range passes the store, or any access beyond a store, returns
// status 1 with zero data.
// ----------------------------------------------------------------------------
module indexed_horner_weight_multiply #(
    parameter int NUM_WEIGHTS = ihwm_pkg::NUM_WEIGHTS_DEF,
    parameter int NUM_COEFFS  = ihwm_pkg::NUM_COEFFS_DEF,
    parameter int MAX_ORDER   = ihwm_pkg::MAX_ORDER_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // weight_index[9:0], coeff_index[17:10], poly_order[21:18],
    // operand_value[69:22], zero[71:70]
    input  logic [ihwm_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,   // last_term
    input  logic [ihwm_pkg::REQ_W-1:0]        s_tuser,   // req_type[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ihwm_pkg::M_TDATA_W-1:0]    m_tdata,   // read_value[47:0]
    output logic                              m_tlast,   // pass_done
    output logic [ihwm_pkg::STAT_W-1:0]       m_tuser    // status[1:0]
);

    localparam int DW = ihwm_pkg::DATA_W;
    localparam int HW = ihwm_pkg::HALF_W;
    localparam int PW = ihwm_pkg::PROD_W;
    localparam int CA_W = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;
    localparam int WA_W = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

    // ------------------------------------------------------------------
    // Input field split
    // ------------------------------------------------------------------
    logic [ihwm_pkg::WIDX_W-1:0]  in_widx;
    logic [ihwm_pkg::CIDX_W-1:0]  in_cidx;
    logic [ihwm_pkg::ORDER_W-1:0] in_order;
    logic [ihwm_pkg::ORDER_W-1:0] in_ord;
    logic [DW-1:0]                in_opv;
    ihwm_pkg::req_t               in_req;
    logic                         s_acc;
    logic                         c_wr_ok;
    logic                         w_ok;
    logic                         poly_ok;

    assign in_widx  = s_tdata[9:0];
    assign in_cidx  = s_tdata[17:10];
    assign in_order = s_tdata[21:18];
    assign in_opv   = s_tdata[69:22];
    assign in_req   = ihwm_pkg::req_t'(s_tuser);
    assign s_acc    = s_tvalid && s_tready;

    // Clamp the order to the supported maximum
    assign in_ord = (32'(in_order) > 32'(MAX_ORDER)) ?
                    ihwm_pkg::ORDER_W'(MAX_ORDER) : in_order;

    assign c_wr_ok = 32'(in_cidx) < 32'(NUM_COEFFS);
    assign w_ok    = 32'(in_widx) < 32'(NUM_WEIGHTS);
    assign poly_ok = (32'(in_cidx) + 32'(in_ord)) < 32'(NUM_COEFFS);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    ihwm_pkg::state_t             state_reg, state_next;
    ihwm_pkg::req_t               req_reg, req_next;
    logic [ihwm_pkg::WIDX_W-1:0]  widx_reg, widx_next;
    logic [ihwm_pkg::CIDX_W-1:0]  cidx_reg, cidx_next;
    logic [ihwm_pkg::ORDER_W-1:0] j_reg, j_next;
    logic [DW-1:0]                x_reg, x_next;
    logic [DW-1:0]                acc_reg, acc_next;
    logic                         wphase_reg, wphase_next;
    logic [DW-1:0]                ua_reg, ua_next;
    logic [DW-1:0]                ub_reg, ub_next;
    logic                         neg_reg, neg_next;
    logic [2:0]                   k_reg, k_next;
    logic [DW-1:0]                pp_reg, pp_next;
    logic [1:0]                   pp_sh_reg, pp_sh_next;
    logic [PW-1:0]                p_reg, p_next;
    logic [DW-1:0]                mres_reg, mres_next;
    logic                         sat_reg, sat_next;
    logic [DW-1:0]                res_val_reg, res_val_next;
    ihwm_pkg::stat_t              res_stat_reg, res_stat_next;
    logic                         res_last_reg, res_last_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [DW-1:0]                m_tdata_reg, m_tdata_next;
    ihwm_pkg::stat_t              m_tuser_reg, m_tuser_next;
    logic                         m_tlast_reg, m_tlast_next;

    assign s_tready = (state_reg == ihwm_pkg::ST_IDLE);

    // ------------------------------------------------------------------
    // Stores: one write port, one registered read port each
    // ------------------------------------------------------------------
    logic [DW-1:0]             coef_mem [NUM_COEFFS];
    logic [DW-1:0]             wgt_mem  [NUM_WEIGHTS];
    logic [DW-1:0]             crd_reg;
    logic [DW-1:0]             wrd_reg;
    logic                      cmem_we;
    logic                      wmem_we;
    logic [DW-1:0]             wmem_wdata;
    logic [WA_W-1:0]           wmem_waddr;
    logic [CA_W-1:0]           cmem_waddr;
    logic [CA_W-1:0]           cmem_raddr;
    logic [WA_W-1:0]           wmem_raddr;
    logic [ihwm_pkg::CIDX_W:0] csum;

    assign csum       = {1'b0, cidx_reg} + {5'b0, j_reg};
    assign cmem_raddr = CA_W'(csum);
    assign cmem_waddr = CA_W'(in_cidx);
    assign wmem_raddr = WA_W'(widx_reg);

    always_ff @(posedge aclk) begin
        if (cmem_we) begin
            coef_mem[cmem_waddr] <= in_opv;
        end
        crd_reg <= coef_mem[cmem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (wmem_we) begin
            wgt_mem[wmem_waddr] <= wmem_wdata;
        end
        wrd_reg <= wgt_mem[wmem_raddr];
    end

    // ------------------------------------------------------------------
    // Shared multiplier datapath
    // ------------------------------------------------------------------
    logic [DW-1:0] op_a;
    logic [DW-1:0] op_b;
    logic [DW-1:0] abs_a;
    logic [DW-1:0] abs_b;
    logic [HW-1:0] a_part;
    logic [HW-1:0] b_part;
    logic [DW-1:0] pp_c;
    logic [PW-1:0] pp_shifted;
    logic [63:0]   q;
    logic          pos_ovf;
    logic          neg_ovf;
    logic [DW-1:0] fin_val;
    logic          fin_sat;
    logic [DW:0]   sum_c;
    logic [DW-1:0] add_val;
    logic          add_sat;

    assign op_a  = wphase_reg ? wrd_reg : acc_reg;
    assign op_b  = wphase_reg ? acc_reg : x_reg;
    assign abs_a = op_a[DW-1] ? (~op_a + 1'b1) : op_a;
    assign abs_b = op_b[DW-1] ? (~op_b + 1'b1) : op_b;

    // Pass order: a0*b0, a0*b1, a1*b0, a1*b1
    assign a_part = k_reg[1] ? ua_reg[DW-1:HW] : ua_reg[HW-1:0];
    assign b_part = k_reg[0] ? ub_reg[DW-1:HW] : ub_reg[HW-1:0];
    assign pp_c   = a_part * b_part;

    always_comb begin
        case (pp_sh_reg)
            2'd1:    pp_shifted = {{(PW-DW-HW){1'b0}}, pp_reg, {HW{1'b0}}};
            2'd2:    pp_shifted = {pp_reg, {DW{1'b0}}};
            default: pp_shifted = {{(PW-DW){1'b0}}, pp_reg};
        endcase
    end

    // Drop the fraction bits, then saturate to the signed range
    assign q       = p_reg[PW-1:ihwm_pkg::FRAC_W];
    assign pos_ovf = q > 64'(ihwm_pkg::Q_MAX);
    assign neg_ovf = q > 64'(ihwm_pkg::Q_MIN);

    always_comb begin
        fin_sat = 1'b0;
        if (neg_reg) begin
            if (neg_ovf) begin
                fin_val = ihwm_pkg::Q_MIN;
                fin_sat = 1'b1;
            end else begin
                fin_val = ~q[DW-1:0] + 1'b1;
            end
        end else begin
            if (pos_ovf) begin
                fin_val = ihwm_pkg::Q_MAX;
                fin_sat = 1'b1;
            end else begin
                fin_val = q[DW-1:0];
            end
        end
    end

    assign sum_c   = {mres_reg[DW-1], mres_reg} + {crd_reg[DW-1], crd_reg};
    assign add_sat = sum_c[DW] != sum_c[DW-1];
    assign add_val = add_sat ? (sum_c[DW] ? ihwm_pkg::Q_MIN : ihwm_pkg::Q_MAX)
                             : sum_c[DW-1:0];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        widx_next     = widx_reg;
        cidx_next     = cidx_reg;
        j_next        = j_reg;
        x_next        = x_reg;
        acc_next      = acc_reg;
        wphase_next   = wphase_reg;
        ua_next       = ua_reg;
        ub_next       = ub_reg;
        neg_next      = neg_reg;
        k_next        = k_reg;
        pp_next       = pp_reg;
        pp_sh_next    = pp_sh_reg;
        p_next        = p_reg;
        mres_next     = mres_reg;
        sat_next      = sat_reg;
        res_val_next  = res_val_reg;
        res_stat_next = res_stat_reg;
        res_last_next = res_last_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        cmem_we       = 1'b0;
        wmem_we       = 1'b0;
        wmem_wdata    = fin_val;
        wmem_waddr    = WA_W'(widx_reg);

        unique case (state_reg)
            ihwm_pkg::ST_IDLE: begin
                if (s_acc) begin
                    req_next      = in_req;
                    widx_next     = in_widx;
                    cidx_next     = in_cidx;
                    j_next        = in_ord;
                    x_next        = in_opv;
                    wphase_next   = 1'b0;
                    sat_next      = 1'b0;
                    res_val_next  = '0;
                    res_stat_next = ihwm_pkg::STAT_RANGE;
                    res_last_next = (in_req == ihwm_pkg::REQ_APPLY) && s_tlast;
                    state_next    = ihwm_pkg::ST_OUT;
                    unique case (in_req)
                        ihwm_pkg::REQ_WR_COEF: begin
                            if (c_wr_ok) begin
                                cmem_we       = 1'b1;
                                res_val_next  = in_opv;
                                res_stat_next = ihwm_pkg::STAT_OK;
                            end
                        end
                        ihwm_pkg::REQ_WR_WEIGHT: begin
                            if (w_ok) begin
                                wmem_we       = 1'b1;
                                wmem_wdata    = in_opv;
                                wmem_waddr    = WA_W'(in_widx);
                                res_val_next  = in_opv;
                                res_stat_next = ihwm_pkg::STAT_OK;
                            end
                        end
                        ihwm_pkg::REQ_RD_WEIGHT: begin
                            if (w_ok) begin
                                state_next = ihwm_pkg::ST_RD_FETCH;
                            end
                        end
                        ihwm_pkg::REQ_APPLY: begin
                            if (w_ok && poly_ok) begin
                                state_next = ihwm_pkg::ST_H_FETCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ihwm_pkg::ST_RD_FETCH: begin
                state_next = ihwm_pkg::ST_RD_TAKE;
            end
            ihwm_pkg::ST_RD_TAKE: begin
                res_val_next  = wrd_reg;
                res_stat_next = ihwm_pkg::STAT_OK;
                state_next    = ihwm_pkg::ST_OUT;
            end
            ihwm_pkg::ST_H_FETCH: begin
                state_next = ihwm_pkg::ST_H_LOAD;
            end
            ihwm_pkg::ST_H_LOAD: begin
                // The first Horner step multiplies zero: take the top coefficient
                acc_next = crd_reg;
                if (j_reg == '0) begin
                    state_next = ihwm_pkg::ST_W_FETCH;
                end else begin
                    j_next     = j_reg - 1'b1;
                    state_next = ihwm_pkg::ST_M_SETUP;
                end
            end
            ihwm_pkg::ST_W_FETCH: begin
                wphase_next = 1'b1;
                state_next  = ihwm_pkg::ST_M_SETUP;
            end
            ihwm_pkg::ST_M_SETUP: begin
                ua_next    = abs_a;
                ub_next    = abs_b;
                neg_next   = op_a[DW-1] ^ op_b[DW-1];
                p_next     = '0;
                k_next     = '0;
                state_next = ihwm_pkg::ST_MUL;
            end
            ihwm_pkg::ST_MUL: begin
                if (k_reg != ihwm_pkg::MUL_STEPS) begin
                    pp_next    = pp_c;
                    pp_sh_next = {1'b0, k_reg[1]} + {1'b0, k_reg[0]};
                end
                if (k_reg != '0) begin
                    p_next = p_reg + pp_shifted;
                end
                k_next = k_reg + 1'b1;
                if (k_reg == ihwm_pkg::MUL_STEPS) begin
                    state_next = ihwm_pkg::ST_FIN;
                end
            end
            ihwm_pkg::ST_FIN: begin
                if (wphase_reg) begin
                    wmem_we       = 1'b1;
                    res_val_next  = fin_val;
                    res_stat_next = (sat_reg || fin_sat) ? ihwm_pkg::STAT_SAT
                                                         : ihwm_pkg::STAT_OK;
                    state_next    = ihwm_pkg::ST_OUT;
                end else begin
                    mres_next  = fin_val;
                    sat_next   = sat_reg || fin_sat;
                    state_next = ihwm_pkg::ST_H_ADD;
                end
            end
            ihwm_pkg::ST_H_ADD: begin
                acc_next = add_val;
                sat_next = sat_reg || add_sat;
                if (j_reg == '0) begin
                    state_next = ihwm_pkg::ST_W_FETCH;
                end else begin
                    j_next     = j_reg - 1'b1;
                    state_next = ihwm_pkg::ST_M_SETUP;
                end
            end
            ihwm_pkg::ST_OUT: begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_val_reg;
                    m_tuser_next  = res_stat_reg;
                    m_tlast_next  = res_last_reg;
                    state_next    = ihwm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ihwm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ihwm_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        widx_reg     <= widx_next;
        cidx_reg     <= cidx_next;
        j_reg        <= j_next;
        x_reg        <= x_next;
        acc_reg      <= acc_next;
        wphase_reg   <= wphase_next;
        ua_reg       <= ua_next;
        ub_reg       <= ub_next;
        neg_reg      <= neg_next;
        k_reg        <= k_next;
        pp_reg       <= pp_next;
        pp_sh_reg    <= pp_sh_next;
        p_reg        <= p_next;
        mres_reg     <= mres_next;
        sat_reg      <= sat_next;
        res_val_reg  <= res_val_next;
        res_stat_reg <= res_stat_next;
        res_last_reg <= res_last_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("block stayed ready after taking a transaction");

    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ihwm_pkg::STAT_RANGE) |-> (m_tdata == '0))
        else $error("range error result carries nonzero data");

    a_fin_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ihwm_pkg::ST_FIN) |->
            ($past(state_reg) == ihwm_pkg::ST_MUL) &&
            ($past(k_reg) == ihwm_pkg::MUL_STEPS))
        else $error("product finished before all partial products were summed");

    a_done_only_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ihwm_pkg::ST_OUT) && res_last_reg |->
            (req_reg == ihwm_pkg::REQ_APPLY))
        else $error("pass_done set on a non-apply transaction");

endmodule

[dv/indexed_horner_weight_multiply_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_horner_weight_multiply_tb
// Self-checking bench for the indexed Horner weight multiplier. A queue of
// requests (directed corners, then write/apply/read passes with random content
// mixed with noise) feeds a stream driver. Each accepted transaction runs
// through a local Q16.32 predictor with its own coefficient and weight stores,
// and the monitor checks every result against the oldest prediction. Phases
// vary sender gaps and receiver stalls, including one long receiver hold.
// ----------------------------------------------------------------------------
module indexed_horner_weight_multiply_tb;

    localparam int DW        = ihwm_pkg::DATA_W;
    localparam int NUM_W     = ihwm_pkg::NUM_WEIGHTS_DEF;
    localparam int NUM_C     = ihwm_pkg::NUM_COEFFS_DEF;
    localparam int ORDER_CAP = ihwm_pkg::MAX_ORDER_DEF;
    localparam logic [DW-1:0] Q_ONE     = 48'h0001_0000_0000;
    localparam logic [DW-1:0] Q_NEG_ONE = 48'hFFFF_0000_0000;

    typedef struct packed {
        ihwm_pkg::req_t               kind;
        logic [ihwm_pkg::WIDX_W-1:0]  widx;
        logic [ihwm_pkg::CIDX_W-1:0]  cidx;
        logic [ihwm_pkg::ORDER_W-1:0] order;
        logic [DW-1:0]                opv;
        logic                         last;
    } horner_req_t;

    typedef struct packed {
        logic [DW-1:0]   value;
        ihwm_pkg::stat_t status;
        logic            done;
    } horner_resp_t;

    logic                                 aclk     = 1'b0;
    logic                                 aresetn  = 1'b0;
    logic                                 s_tvalid = 1'b0;
    logic                                 s_tready;
    logic [ihwm_pkg::S_TDATA_W-1:0]       s_tdata  = '0;
    logic                                 s_tlast  = 1'b0;
    logic [ihwm_pkg::REQ_W-1:0]           s_tuser  = '0;
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    logic [ihwm_pkg::M_TDATA_W-1:0]       m_tdata;
    logic                                 m_tlast;
    logic [ihwm_pkg::STAT_W-1:0]          m_tuser;

    // Predictor state
    logic [DW-1:0] coef_mem   [NUM_C];
    logic [DW-1:0] weight_mem [NUM_W];

    // Generator bookkeeping: which entries may be read
    bit coef_known [NUM_C];
    bit wt_known   [NUM_W];
    int wt_list[$];

    horner_req_t  req_backlog[$];
    horner_resp_t resp_due[$];
    horner_req_t  tx_item;

    int queued_cnt    = 0;
    int err_cnt       = 0;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int phase_no      = 0;
    logic rx_hold     = 1'b0;

    indexed_horner_weight_multiply uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Q16.32 product, truncated toward zero, saturated
    function automatic logic [DW-1:0] q_mul(input logic [DW-1:0] a,
                                            input logic [DW-1:0] b,
                                            inout bit sat);
        logic [DW-1:0]               ua;
        logic [DW-1:0]               ub;
        logic [ihwm_pkg::PROD_W-1:0] prod;
        logic [63:0]                 q;
        ua = a[DW-1] ? -a : a;
        ub = b[DW-1] ? -b : b;
        prod = {{DW{1'b0}}, ua} * {{DW{1'b0}}, ub};
        q = prod[ihwm_pkg::PROD_W-1:ihwm_pkg::FRAC_W];
        if (a[DW-1] ^ b[DW-1]) begin
            if (q > 64'h8000_0000_0000) begin
                sat = 1'b1;
                return ihwm_pkg::Q_MIN;
            end
            return -q[DW-1:0];
        end
        if (q > 64'h7FFF_FFFF_FFFF) begin
            sat = 1'b1;
            return ihwm_pkg::Q_MAX;
        end
        return q[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] q_add(input logic [DW-1:0] a,
                                            input logic [DW-1:0] b,
                                            inout bit sat);
        logic [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            sat = 1'b1;
            return s[DW] ? ihwm_pkg::Q_MIN : ihwm_pkg::Q_MAX;
        end
        return s[DW-1:0];
    endfunction

    // Update the local stores and return the result the block must give
    function automatic horner_resp_t predict_response(input horner_req_t it);
        horner_resp_t r;
        logic [DW-1:0] acc;
        bit sat;
        int n;
        r.value  = '0;
        r.status = ihwm_pkg::STAT_OK;
        r.done   = 1'b0;
        case (it.kind)
            ihwm_pkg::REQ_WR_COEF: begin
                coef_mem[it.cidx] = it.opv;
                r.value = it.opv;
            end
            ihwm_pkg::REQ_WR_WEIGHT: begin
                weight_mem[it.widx] = it.opv;
                r.value = it.opv;
            end
            ihwm_pkg::REQ_RD_WEIGHT: r.value = weight_mem[it.widx];
            ihwm_pkg::REQ_APPLY: begin
                r.done = it.last;
                n = (int'(it.order) > ORDER_CAP) ? ORDER_CAP : int'(it.order);
                if (int'(it.cidx) + n >= NUM_C) begin
                    r.status = ihwm_pkg::STAT_RANGE;
                end else begin
                    sat = 1'b0;
                    acc = '0;
                    for (int j = n; j >= 0; j--) begin
                        acc = q_mul(acc, it.opv, sat);
                        acc = q_add(acc, coef_mem[int'(it.cidx) + j], sat);
                    end
                    r.value = q_mul(weight_mem[it.widx], acc, sat);
                    weight_mem[it.widx] = r.value;
                    if (sat) r.status = ihwm_pkg::STAT_SAT;
                end
            end
            default: r.status = ihwm_pkg::STAT_RANGE;
        endcase
        return r;
    endfunction

    function automatic logic [DW-1:0] rand_q();
        logic [33:0] near_one;
        logic [DW-1:0] v;
        near_one = {2'($urandom()), $urandom()};
        case ($urandom_range(0, 9))
            0, 1: v = {16'($urandom()), $urandom()};
            2: begin
                case ($urandom_range(0, 4))
                    0: v = ihwm_pkg::Q_MAX;
                    1: v = ihwm_pkg::Q_MIN;
                    2: v = '0;
                    3: v = Q_ONE;
                    default: v = Q_NEG_ONE;
                endcase
            end
            default: v = {{(DW-34){near_one[33]}}, near_one};
        endcase
        return v;
    endfunction

    task automatic push_req(input ihwm_pkg::req_t kind, input int widx, input int cidx,
                            input int order, input logic [DW-1:0] opv,
                            input logic last);
        horner_req_t it;
        it.kind  = kind;
        it.widx  = ihwm_pkg::WIDX_W'(widx);
        it.cidx  = ihwm_pkg::CIDX_W'(cidx);
        it.order = ihwm_pkg::ORDER_W'(order);
        it.opv   = opv;
        it.last  = last;
        if (kind == ihwm_pkg::REQ_WR_COEF) coef_known[it.cidx] = 1'b1;
        if (kind == ihwm_pkg::REQ_WR_WEIGHT && !wt_known[it.widx]) begin
            wt_known[it.widx] = 1'b1;
            wt_list.push_back(int'(it.widx));
        end
        req_backlog.push_back(it);
        queued_cnt++;
    endtask

    // Load coefficients and a weight, apply one or more terms, maybe read back
    task automatic add_pass();
        int n;
        int c;
        int w;
        int reps;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, ORDER_CAP) : $urandom_range(0, 4);
        c = $urandom_range(0, NUM_C - 1 - n);
        if (wt_list.size() != 0 && $urandom_range(0, 1) == 1)
            w = wt_list[$urandom_range(0, wt_list.size() - 1)];
        else
            w = $urandom_range(0, NUM_W - 1);
        for (int k = c; k <= c + n; k++) begin
            if (!coef_known[k] || $urandom_range(0, 3) == 0)
                push_req(ihwm_pkg::REQ_WR_COEF, $urandom_range(0, NUM_W - 1), k,
                         $urandom_range(0, 15), rand_q(), 1'($urandom_range(0, 1)));
        end
        if (!wt_known[w] || $urandom_range(0, 1) == 1)
            push_req(ihwm_pkg::REQ_WR_WEIGHT, w, $urandom_range(0, NUM_C - 1),
                     $urandom_range(0, 15), rand_q(), 1'($urandom_range(0, 1)));
        reps = $urandom_range(1, 3);
        for (int k = 0; k < reps; k++)
            push_req(ihwm_pkg::REQ_APPLY, w, c, n, rand_q(), k == reps - 1);
        if ($urandom_range(0, 1) == 1)
            push_req(ihwm_pkg::REQ_RD_WEIGHT, w, $urandom_range(0, NUM_C - 1),
                     $urandom_range(0, 15), rand_q(), 1'($urandom_range(0, 1)));
    endtask

    // Stray writes, reads of known weights, and applies past the coefficient store
    task automatic add_noise();
        int n;
        case ($urandom_range(0, 3))
            0: push_req(ihwm_pkg::REQ_WR_COEF, $urandom_range(0, NUM_W - 1),
                        $urandom_range(0, NUM_C - 1), $urandom_range(0, 15), rand_q(),
                        1'($urandom_range(0, 1)));
            1: push_req(ihwm_pkg::REQ_WR_WEIGHT, $urandom_range(0, NUM_W - 1),
                        $urandom_range(0, NUM_C - 1), $urandom_range(0, 15), rand_q(),
                        1'($urandom_range(0, 1)));
            2: begin
                if (wt_list.size() != 0)
                    push_req(ihwm_pkg::REQ_RD_WEIGHT,
                             wt_list[$urandom_range(0, wt_list.size() - 1)],
                             $urandom_range(0, NUM_C - 1), $urandom_range(0, 15), rand_q(),
                             1'($urandom_range(0, 1)));
            end
            default: begin
                n = $urandom_range(1, ORDER_CAP);
                push_req(ihwm_pkg::REQ_APPLY, $urandom_range(0, NUM_W - 1),
                         $urandom_range(NUM_C - n, NUM_C - 1), n, rand_q(),
                         1'($urandom_range(0, 1)));
            end
        endcase
    endtask

    task automatic load_directed();
        push_req(ihwm_pkg::REQ_WR_COEF,   0,    0,   0,  ihwm_pkg::Q_MAX, 1'b0);
        push_req(ihwm_pkg::REQ_WR_COEF,   0,    1,   0,  Q_ONE,           1'b1);
        push_req(ihwm_pkg::REQ_WR_COEF,   1023, 2,   15, ihwm_pkg::Q_MIN, 1'b0);
        push_req(ihwm_pkg::REQ_WR_COEF,   0,    255, 0,  Q_NEG_ONE,       1'b0);
        push_req(ihwm_pkg::REQ_WR_WEIGHT, 0,    0,   0,  Q_ONE,           1'b0);
        push_req(ihwm_pkg::REQ_WR_WEIGHT, 1023, 255, 15, ihwm_pkg::Q_MIN, 1'b1);
        push_req(ihwm_pkg::REQ_WR_WEIGHT, 5,    0,   0,  ihwm_pkg::Q_MAX, 1'b0);
        push_req(ihwm_pkg::REQ_RD_WEIGHT, 1023, 0,   0,  '0,              1'b0);
        push_req(ihwm_pkg::REQ_RD_WEIGHT, 0,    255, 15, ihwm_pkg::Q_MIN, 1'b1);
        // constant polynomial, then a sum that saturates
        push_req(ihwm_pkg::REQ_APPLY,     0,    1,   0,  '0,              1'b1);
        push_req(ihwm_pkg::REQ_APPLY,     0,    0,   1,  Q_ONE,           1'b0);
        // extreme argument: saturates in both the Horner step and the weight multiply
        push_req(ihwm_pkg::REQ_APPLY,     1023, 1,   1,  ihwm_pkg::Q_MIN, 1'b1);
        // top coefficient entry with order zero is still in range
        push_req(ihwm_pkg::REQ_APPLY,     5,    255, 0,  ihwm_pkg::Q_MAX, 1'b0);
        // ranges past the store; range error outranks saturation
        push_req(ihwm_pkg::REQ_APPLY,     5,    255, 1,  ihwm_pkg::Q_MAX, 1'b1);
        push_req(ihwm_pkg::REQ_APPLY,     1023, 241, 15, ihwm_pkg::Q_MIN, 1'b0);
        push_req(ihwm_pkg::REQ_RD_WEIGHT, 5,    0,   0,  '0,              1'b0);
        push_req(ihwm_pkg::REQ_WR_COEF,   512,  128, 15, '0,              1'b1);
        push_req(ihwm_pkg::REQ_APPLY,     5,    128, 0,  ihwm_pkg::Q_MAX, 1'b1);
        push_req(ihwm_pkg::REQ_RD_WEIGHT, 5,    0,   0,  '0,              1'b0);
        push_req(ihwm_pkg::REQ_RD_WEIGHT, 1023, 0,   0,  '0,              1'b0);
    endtask

    task automatic wait_drained();
        while (req_backlog.size() != 0 || s_tvalid || resp_due.size() != 0)
            @(negedge aclk);
    endtask

    task automatic run_phase(input int n_items, input int src_pct, input int snk_pct);
        int start;
        @(negedge aclk);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        phase_no++;
        start = queued_cnt;
        while (queued_cnt - start < n_items) begin
            if ($urandom_range(0, 9) < 7) add_pass();
            else add_noise();
        end
        wait_drained();
    endtask

    // Stream driver: predict on each accepted transaction, then offer the next
    always @(posedge aclk) begin : tx_driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) resp_due.push_back(predict_response(tx_item));
            if (!s_tvalid || s_tready) begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    tx_item = req_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, tx_item.opv, tx_item.order, tx_item.cidx, tx_item.widx};
                    s_tlast  <= tx_item.last;
                    s_tuser  <= tx_item.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : rx_monitor
        horner_resp_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (resp_due.size() == 0) begin
                    $error("result with no transaction outstanding: read_value %h", m_tdata);
                    err_cnt++;
                end else begin
                    want = resp_due.pop_front();
                    if (m_tdata !== want.value) begin
                        $error("read_value: expected %h, got %h", want.value, m_tdata);
                        err_cnt++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        err_cnt++;
                    end
                    if (m_tlast !== want.done) begin
                        $error("pass_done: expected %0d, got %0d", want.done, m_tlast);
                        err_cnt++;
                    end
                end
            end
            m_tready <= !rx_hold && ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // Hold the receiver off long enough that the block backs up and drops s_tready
    initial begin
        wait (phase_no == 1);
        repeat (20) @(negedge aclk);
        rx_hold = 1'b1;
        repeat (400) @(negedge aclk);
        rx_hold = 1'b0;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        load_directed();
        wait_drained();
        run_phase(500, 0, 0);
        run_phase(300, 48, 0);
        run_phase(300, 0, 48);
        run_phase(300, 11, 11);
        run_phase(300, 0, 0);
        repeat (200) @(negedge aclk);
        if (err_cnt == 0)
            $display("[indexed_horner_weight_multiply] OK");
        else
            $display("[indexed_horner_weight_multiply] ERROR");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("[indexed_horner_weight_multiply] ERROR");
        $finish;
    end

endmodule

[sim.f]
src/ihwm_pkg.sv
src/indexed_horner_weight_multiply.sv
dv/indexed_horner_weight_multiply_tb.sv
